>>> src/dtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_pkg: shared types and constants of the detector event framer
// Field widths, record kinds, register indexes and the queue entry format.
// ----------------------------------------------------------------------------
package dtf_pkg;

  // input field widths
  localparam int unsigned TimeW   = 64;
  localparam int unsigned RawW    = 16;
  localparam int unsigned FlagW   = 32;

  // output field widths
  localparam int unsigned FrameW  = 32;
  localparam int unsigned IndexW  = 48;
  localparam int unsigned EnergyW = 15;
  localparam int unsigned CalW    = 48;
  localparam int unsigned CfgW    = 32;

  // stream widths
  localparam int unsigned InDataW  = TimeW + RawW + FlagW;                      // 112
  localparam int unsigned OutUsedW = FrameW + IndexW + TimeW + EnergyW + CalW + FlagW;
  localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;                 // 240
  localparam int unsigned OutPadW  = OutDataW - OutUsedW;

  // classification constants
  localparam logic [FlagW-1:0] FakeFlag      = 32'h0000_0008;
  localparam int unsigned      FakeBit       = 3;
  localparam logic [RawW-1:0]  EnergyInvalid = 16'sd32767;

  // record kinds
  localparam logic KindFrame    = 1'b0;
  localparam logic KindDetector = 1'b1;

  // configuration register indexes
  localparam logic RegGain   = 1'b0;
  localparam logic RegOffset = 1'b1;

  // reset values of the configuration registers
  localparam logic [CfgW-1:0] GainReset   = 32'h0001_0000;
  localparam logic [CfgW-1:0] OffsetReset = 32'h0000_0000;

  // decoupling queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // one classified record waiting for the back end
  typedef struct packed {
    logic               kind;
    logic [FrameW-1:0]  frame_number;
    logic [IndexW-1:0]  first_event_index;
    logic [TimeW-1:0]   time_ps;
    logic [EnergyW-1:0] energy_value;
    logic [FlagW-1:0]   flag_word;
  } entry_t;

  // front end to queue write side
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_wr_t;

  // queue read side status toward the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_rd_t;

endpackage

>>> src/dtf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_front: event classifier and run state
// Accepts raw events, tracks reference / frame state and emits records.
// ----------------------------------------------------------------------------
module dtf_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dtf_pkg::InDataW-1:0]      in_data_i,
  input  logic                             queue_full_i,
  output dtf_pkg::queue_wr_t               queue_wr_o
);

  logic [dtf_pkg::TimeW-1:0]  ref_time_q, ref_time_d;
  logic                       ref_valid_q, ref_valid_d;
  logic                       frame_seen_q, frame_seen_d;
  logic [dtf_pkg::FrameW-1:0] next_frame_q, next_frame_d;
  logic [dtf_pkg::TimeW-1:0]  frame_t0_q, frame_t0_d;
  logic [dtf_pkg::IndexW-1:0] det_count_q, det_count_d;

  logic [dtf_pkg::TimeW-1:0]  trig_time;
  logic [dtf_pkg::RawW-1:0]   raw_energy;
  logic [dtf_pkg::FlagW-1:0]  flags;
  logic                       accept;
  logic                       is_marker;
  logic                       is_real;
  logic [dtf_pkg::TimeW-1:0]  eff_ref;
  logic [dtf_pkg::TimeW-1:0]  since_ref;
  logic [dtf_pkg::TimeW-1:0]  since_frame;

  // unpack the input beat
  assign trig_time  = in_data_i[dtf_pkg::TimeW-1:0];
  assign raw_energy = in_data_i[dtf_pkg::TimeW +: dtf_pkg::RawW];
  assign flags      = in_data_i[dtf_pkg::TimeW + dtf_pkg::RawW +: dtf_pkg::FlagW];

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // classification
  assign is_marker = (flags == dtf_pkg::FakeFlag) && (raw_energy == '0);
  assign is_real   = !raw_energy[dtf_pkg::RawW-1] && (raw_energy != '0) &&
                     (raw_energy != dtf_pkg::EnergyInvalid) && !flags[dtf_pkg::FakeBit];

  // first event of the run becomes its own reference
  assign eff_ref     = ref_valid_q ? ref_time_q : trig_time;
  assign since_ref   = trig_time - eff_ref;
  assign since_frame = trig_time - frame_t0_q;

  // record build and state update
  always_comb begin
    ref_time_d    = ref_time_q;
    ref_valid_d   = ref_valid_q;
    frame_seen_d  = frame_seen_q;
    next_frame_d  = next_frame_q;
    frame_t0_d    = frame_t0_q;
    det_count_d   = det_count_q;

    queue_wr_o.valid                   = 1'b0;
    queue_wr_o.entry.kind              = dtf_pkg::KindFrame;
    queue_wr_o.entry.frame_number      = next_frame_q;
    queue_wr_o.entry.first_event_index = det_count_q;
    queue_wr_o.entry.time_ps           = since_ref;
    queue_wr_o.entry.energy_value      = '0;
    queue_wr_o.entry.flag_word         = '0;

    if (accept) begin
      ref_time_d  = eff_ref;
      ref_valid_d = 1'b1;
      if (is_marker) begin
        queue_wr_o.valid = 1'b1;
        frame_t0_d       = trig_time;
        next_frame_d     = next_frame_q + 1'b1;
        frame_seen_d     = 1'b1;
      end else if (frame_seen_q && is_real) begin
        queue_wr_o.valid                   = 1'b1;
        queue_wr_o.entry.kind              = dtf_pkg::KindDetector;
        queue_wr_o.entry.frame_number      = next_frame_q - 1'b1;
        queue_wr_o.entry.first_event_index = '0;
        queue_wr_o.entry.time_ps           = since_frame;
        queue_wr_o.entry.energy_value      = raw_energy[dtf_pkg::EnergyW-1:0];
        queue_wr_o.entry.flag_word         = flags;
        det_count_d                        = det_count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_time_q    <= '0;
      ref_valid_q   <= 1'b0;
      frame_seen_q  <= 1'b0;
      next_frame_q  <= '0;
      frame_t0_q    <= '0;
      det_count_q   <= '0;
    end else begin
      ref_time_q    <= ref_time_d;
      ref_valid_q   <= ref_valid_d;
      frame_seen_q  <= frame_seen_d;
      next_frame_q  <= next_frame_d;
      frame_t0_q    <= frame_t0_d;
      det_count_q   <= det_count_d;
    end
  end

endmodule

>>> src/dtf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_queue: short record queue between front and back end
// Register-based FIFO; full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module dtf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtf_pkg::queue_wr_t wr_i,
  output logic               full_o,
  output dtf_pkg::queue_rd_t rd_o,
  input  logic               pop_i
);

  dtf_pkg::entry_t                 mem_q [dtf_pkg::QueueDepth];
  logic [dtf_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [dtf_pkg::QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [dtf_pkg::QueueCntW-1:0]   count_q, count_d;
  logic                            push;
  logic                            pop;

  assign full_o      = (count_q == dtf_pkg::QueueCntW'(dtf_pkg::QueueDepth));
  assign rd_o.valid  = (count_q != '0);
  assign rd_o.entry  = mem_q[rd_ptr_q];

  assign push = wr_i.valid && !full_o;
  assign pop  = pop_i && rd_o.valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.entry;
    end
  end

endmodule

>>> src/dtf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_back: energy calibration and output register
// Stage 1 multiplies gain by raw energy, stage 2 adds the offset and
// holds the outgoing beat.
// ----------------------------------------------------------------------------
module dtf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dtf_pkg::CfgW-1:0]      gain_i,
  input  logic [dtf_pkg::CfgW-1:0]      offset_i,
  input  dtf_pkg::queue_rd_t            rd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [dtf_pkg::OutDataW-1:0]  out_data_o
);

  logic                         s1_valid_q, s1_valid_d;
  dtf_pkg::entry_t              s1_entry_q;
  logic signed [dtf_pkg::CalW-1:0] s1_prod_q;

  logic                         out_valid_q, out_valid_d;
  logic                         out_kind_q;
  logic [dtf_pkg::OutDataW-1:0] out_data_q;

  logic                         out_adv;
  logic                         s1_adv;
  logic signed [dtf_pkg::CfgW-1:0]    gain_s;
  logic signed [dtf_pkg::EnergyW:0]   energy_s;
  logic signed [dtf_pkg::CalW-1:0]    prod;
  logic signed [dtf_pkg::CalW-1:0]    offset_ext;
  logic [dtf_pkg::CalW-1:0]           cal;

  // stage handshakes
  assign out_adv = !out_valid_q || out_ready_i;
  assign s1_adv  = s1_valid_q && out_adv;
  assign pop_o   = rd_i.valid && (!s1_valid_q || out_adv);

  // gain times raw energy (energy is never negative here)
  assign gain_s   = gain_i;
  assign energy_s = {1'b0, rd_i.entry.energy_value};
  assign prod     = gain_s * energy_s;

  // offset after multiplication; frame records carry zero
  assign offset_ext = {{(dtf_pkg::CalW - dtf_pkg::CfgW){offset_i[dtf_pkg::CfgW-1]}}, offset_i};
  assign cal = (s1_entry_q.kind == dtf_pkg::KindDetector) ?
               dtf_pkg::CalW'(s1_prod_q + offset_ext) : '0;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_entry_q <= rd_i.entry;
      s1_prod_q  <= prod;
    end
    if (s1_adv) begin
      out_kind_q <= s1_entry_q.kind;
      out_data_q <= {{dtf_pkg::OutPadW{1'b0}},
                     s1_entry_q.flag_word,
                     cal,
                     s1_entry_q.energy_value,
                     s1_entry_q.time_ps,
                     s1_entry_q.first_event_index,
                     s1_entry_q.frame_number};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;

endmodule

>>> src/detector_event_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_event_framer: digitizer event framer with energy calibration
//
// Input stream (s_axis_*): one raw event per beat. Output stream (m_axis_*):
// at most one record per event, a frame record (tuser 0) for each frame
// marker and a detector record (tuser 1) for each real event after the
// first marker. Other events are dropped. The config channel (cfg_*) writes
// energy_gain (index 0) and energy_offset (index 1); it is always ready and
// should only be written while the framer is idle.
// Path: the queue is written at the edge that accepts an event, then the
// record passes the multiply stage and the offset add into the output
// register, from which it leaves on m_axis once tready is high.
// Throughput: one event per cycle while the queue is not full; the gain
// multiplier and output register are both fully pipelined.
// Reset clears the run state (reference, frame number, event count), empties
// the queue and restores gain 1.0 and offset 0.
// When the receiver stalls, the output register holds its beat, the
// multiply stage fills, then the four-entry queue; tready drops only once
// the queue is full. Dropped events pass even then only when space exists.
// ----------------------------------------------------------------------------
module detector_event_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // raw events
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dtf_pkg::InDataW-1:0]   s_axis_tdata,   // trigger_time_ps[63:0], raw_energy[79:64], extra_flags[111:80]
  // records
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dtf_pkg::OutDataW-1:0]  m_axis_tdata,   // frame_number[31:0], first_event_index[79:32],
                                                        // time_ps[143:80], energy_value[158:144],
                                                        // energy_calibrated[206:159], flag_word[238:207]
  output logic                          m_axis_tuser,   // record_kind[0]
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [dtf_pkg::CfgW-1:0]      cfg_data_i
);

  logic [dtf_pkg::CfgW-1:0] gain_q, gain_d;
  logic [dtf_pkg::CfgW-1:0] offset_q, offset_d;

  dtf_pkg::queue_wr_t queue_wr;
  dtf_pkg::queue_rd_t queue_rd;
  logic               queue_full;
  logic               queue_pop;

  // calibration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    gain_d   = gain_q;
    offset_d = offset_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        dtf_pkg::RegGain:   gain_d   = cfg_data_i;
        dtf_pkg::RegOffset: offset_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= dtf_pkg::GainReset;
      offset_q <= dtf_pkg::OffsetReset;
    end else begin
      gain_q   <= gain_d;
      offset_q <= offset_d;
    end
  end

  dtf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .queue_full_i (queue_full),
    .queue_wr_o   (queue_wr)
  );

  dtf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (queue_wr),
    .full_o (queue_full),
    .rd_o   (queue_rd),
    .pop_i  (queue_pop)
  );

  dtf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .offset_i    (offset_q),
    .rd_i        (queue_rd),
    .pop_o       (queue_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> tb/event_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_record_checker: record predictor and comparator for the framer
// Watches the config, event and record channels. Each accepted event runs
// through a local model of the frame and calibration logic. Any record it
// yields is queued, and every record beat must match the oldest queued one.
// ----------------------------------------------------------------------------
module event_record_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // raw events
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [dtf_pkg::InDataW-1:0]  s_axis_tdata,
  // records
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [dtf_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         m_axis_tuser,
  // configuration writes
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [dtf_pkg::CfgW-1:0]     cfg_data_i,
  // status toward the test top
  output int unsigned                  records_due_o,
  output int unsigned                  mismatch_count_o
);

  // record field offsets in m_axis_tdata
  localparam int unsigned IndexLo  = dtf_pkg::FrameW;
  localparam int unsigned TimeLo   = IndexLo + dtf_pkg::IndexW;
  localparam int unsigned EnergyLo = TimeLo + dtf_pkg::TimeW;
  localparam int unsigned CalLo    = EnergyLo + dtf_pkg::EnergyW;
  localparam int unsigned FlagsLo  = CalLo + dtf_pkg::CalW;
  localparam int unsigned PrintCap = 200;

  typedef struct packed {
    logic                        kind;
    logic [dtf_pkg::FrameW-1:0]  frame_number;
    logic [dtf_pkg::IndexW-1:0]  first_index;
    logic [dtf_pkg::TimeW-1:0]   time_ps;
    logic [dtf_pkg::EnergyW-1:0] energy;
    logic [dtf_pkg::CalW-1:0]    calibrated;
    logic [dtf_pkg::FlagW-1:0]   flags;
  } record_t;

  // run state of the local model
  logic [dtf_pkg::TimeW-1:0]       run_ref_time;
  logic                            run_ref_valid;
  logic                            frame_open;
  logic [dtf_pkg::FrameW-1:0]      frame_next;
  logic [dtf_pkg::TimeW-1:0]       frame_origin;
  logic [dtf_pkg::IndexW-1:0]      hits_total;
  logic signed [dtf_pkg::CfgW-1:0] cal_gain;
  logic signed [dtf_pkg::CfgW-1:0] cal_offset;

  record_t     records_due[$];
  int unsigned mismatch_total;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_total < PrintCap)
      $display("%0t record check: %s got %h want %h", $time, field, got, want);
    mismatch_total++;
  endtask

  // frame marker / detector hit classification, queues the expected record
  task automatic frame_and_calibrate(input logic [dtf_pkg::TimeW-1:0] stamp,
                                     input logic signed [dtf_pkg::RawW-1:0] raw,
                                     input logic [dtf_pkg::FlagW-1:0] flags);
    record_t rec;
    longint  cal;
    rec = '0;
    if (!run_ref_valid) begin
      run_ref_time  = stamp;
      run_ref_valid = 1'b1;
    end
    if (flags == dtf_pkg::FakeFlag && raw == 0) begin
      rec.kind         = dtf_pkg::KindFrame;
      rec.frame_number = frame_next;
      rec.first_index  = hits_total;
      rec.time_ps      = stamp - run_ref_time;
      records_due.push_back(rec);
      frame_origin = stamp;
      frame_next   = frame_next + 32'd1;
      frame_open   = 1'b1;
    end else if (frame_open && raw > 0 && raw != dtf_pkg::EnergyInvalid &&
                 !flags[dtf_pkg::FakeBit]) begin
      cal = longint'(cal_gain) * longint'(raw) + longint'(cal_offset);
      rec.kind         = dtf_pkg::KindDetector;
      rec.frame_number = frame_next - 32'd1;
      rec.time_ps      = stamp - frame_origin;
      rec.energy       = raw[dtf_pkg::EnergyW-1:0];
      rec.calibrated   = cal[dtf_pkg::CalW-1:0];
      rec.flags        = flags;
      records_due.push_back(rec);
      hits_total = hits_total + 48'd1;
    end
  endtask

  task automatic compare_record();
    record_t want;
    if (records_due.size() == 0) begin
      report_mismatch("record with none expected, kind", m_axis_tuser, '0);
    end else begin
      want = records_due.pop_front();
      if (m_axis_tuser != want.kind)
        report_mismatch("record_kind", m_axis_tuser, want.kind);
      if (m_axis_tdata[IndexLo-1:0] != want.frame_number)
        report_mismatch("frame_number", m_axis_tdata[IndexLo-1:0], want.frame_number);
      if (m_axis_tdata[TimeLo-1:IndexLo] != want.first_index)
        report_mismatch("first_event_index", m_axis_tdata[TimeLo-1:IndexLo],
                        want.first_index);
      if (m_axis_tdata[EnergyLo-1:TimeLo] != want.time_ps)
        report_mismatch("time_ps", m_axis_tdata[EnergyLo-1:TimeLo], want.time_ps);
      if (m_axis_tdata[CalLo-1:EnergyLo] != want.energy)
        report_mismatch("energy_value", m_axis_tdata[CalLo-1:EnergyLo], want.energy);
      if (m_axis_tdata[FlagsLo-1:CalLo] != want.calibrated)
        report_mismatch("energy_calibrated", m_axis_tdata[FlagsLo-1:CalLo],
                        want.calibrated);
      if (m_axis_tdata[FlagsLo+dtf_pkg::FlagW-1:FlagsLo] != want.flags)
        report_mismatch("flag word", m_axis_tdata[FlagsLo+dtf_pkg::FlagW-1:FlagsLo],
                        want.flags);
    end
  endtask

  // sample all channels at the clock edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      run_ref_time  = '0;
      run_ref_valid = 1'b0;
      frame_open    = 1'b0;
      frame_next    = '0;
      frame_origin  = '0;
      hits_total    = '0;
      cal_gain      = dtf_pkg::GainReset;
      cal_offset    = dtf_pkg::OffsetReset;
      records_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == dtf_pkg::RegGain) cal_gain = cfg_data_i;
        else                                 cal_offset = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        frame_and_calibrate(s_axis_tdata[dtf_pkg::TimeW-1:0],
                            s_axis_tdata[dtf_pkg::TimeW+dtf_pkg::RawW-1:dtf_pkg::TimeW],
                            s_axis_tdata[dtf_pkg::InDataW-1:dtf_pkg::TimeW+dtf_pkg::RawW]);
      if (m_axis_tvalid && m_axis_tready)
        compare_record();
    end
    records_due_o    <= records_due.size();
    mismatch_count_o <= mismatch_total;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for detector_event_framer
// Drives raw events through a directed opening and random phases under
// several calibration settings, with random idle bursts on both streams.
// Record checking is done by event_record_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned PhaseItems = 120;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned CycleLimit = 300000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [dtf_pkg::InDataW-1:0]  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [dtf_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic                         cfg_index_i;
  logic [dtf_pkg::CfgW-1:0]     cfg_data_i;

  int unsigned   records_due;
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   ready_hold;
  logic          calm;
  logic [dtf_pkg::TimeW-1:0] stamp;

  detector_event_framer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  event_record_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .records_due_o    (records_due),
    .mismatch_count_o (mismatch_count)
  );

  always #10 clk_i = ~clk_i;

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // record receiver: random stall bursts, none once calm
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!calm && m_axis_tready && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold    <= $urandom_range(0, 20);
    end
  end

  // one event beat, with an optional idle burst ahead of it
  task automatic push_event(input logic [dtf_pkg::TimeW-1:0] ts,
                            input logic [dtf_pkg::RawW-1:0] raw,
                            input logic [dtf_pkg::FlagW-1:0] flags);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {flags, raw, ts};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // mostly well-formed traffic: markers, real hits, and some junk
  task automatic random_event();
    int unsigned               pick;
    logic [dtf_pkg::RawW-1:0]  raw;
    logic [dtf_pkg::FlagW-1:0] flags;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) stamp = {$urandom, $urandom};
    else                            stamp = stamp + $urandom_range(1, 200000);
    if (pick < 8) begin
      raw   = '0;
      flags = dtf_pkg::FakeFlag;
    end else if (pick < 78) begin
      case ($urandom_range(0, 15))
        0:       raw = 16'd1;
        1:       raw = 16'd32766;
        default: raw = 16'($urandom_range(1, 32766));
      endcase
      flags = $urandom & ~dtf_pkg::FakeFlag;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          raw   = dtf_pkg::EnergyInvalid;
          flags = $urandom & ~dtf_pkg::FakeFlag;
        end
        1: begin
          raw   = ($urandom_range(0, 3) == 0) ? 16'h0000 : {1'b1, 15'($urandom)};
          flags = $urandom & ~dtf_pkg::FakeFlag;
        end
        2: begin
          raw   = 16'($urandom);
          flags = $urandom | dtf_pkg::FakeFlag;
        end
        default: begin
          raw   = 16'($urandom_range(1, 65535));
          flags = dtf_pkg::FakeFlag;
        end
      endcase
    end
    push_event(stamp, raw, flags);
  endtask

  task automatic write_reg(input logic idx, input logic [dtf_pkg::CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // stop input, let every record drain and dropped events clear the pipe
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (records_due != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [dtf_pkg::CfgW-1:0] gain,
                           input logic [dtf_pkg::CfgW-1:0] offset);
    settle();
    write_reg(dtf_pkg::RegGain, gain);
    write_reg(dtf_pkg::RegOffset, offset);
    cfg_valid_i <= 1'b0;
    repeat (PhaseItems) random_event();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = dtf_pkg::RegGain;
    cfg_data_i    = '0;
    calm          = 1'b0;
    stamp         = 64'd10000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: drops before the first frame, then edge cases per kind
    push_event(64'd1000, 16'd500, 32'h0);                // sets reference, dropped
    push_event(64'd1100, 16'd100, dtf_pkg::FakeFlag);    // fake, not a marker
    push_event(64'd5000, 16'h0000, dtf_pkg::FakeFlag);   // first frame
    push_event(64'd5100, 16'd1, 32'h0);
    push_event(64'd5200, 16'd32766, 32'hFFFF_FFF7);
    push_event(64'd5300, dtf_pkg::EnergyInvalid, 32'h0); // saturated energy
    push_event(64'd5400, 16'h8000, 32'h0);               // most negative
    push_event(64'd5500, 16'hFFFF, 32'h0);
    push_event(64'd5600, 16'h0000, 32'h0);
    push_event(64'd5700, 16'd200, 32'hFFFF_FFFF);        // fake bit among others
    push_event(64'd5800, 16'h0000, 32'h0000_0018);       // not exactly the fake flag
    push_event(64'd5900, 16'd5, dtf_pkg::FakeFlag);      // marker flag, nonzero energy
    push_event(64'd0, 16'h0000, dtf_pkg::FakeFlag);      // time goes backwards
    push_event(64'hFFFF_FFFF_FFFF_FFFF, 16'd16384, 32'h5555_5550);
    push_event(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, dtf_pkg::FakeFlag);
    push_event(64'd0, 16'd12345, 32'hAAAA_AAA2);         // wraps past frame start
    push_event(64'h8000_0000_0000_0000, 16'd32766, 32'h0);
    push_event(64'h8000_0000_0000_0001, 16'h0000, dtf_pkg::FakeFlag);

    // random phases over calibration extremes and random settings
    run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_phase(32'h8000_0000, 32'h8000_0000);
    run_phase(32'h0000_0000, $urandom);
    run_phase($urandom, $urandom);
    settle();
    calm = 1'b1;
    run_phase($urandom, 32'h0000_0000);

    settle();
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
